// ===== hw/rtl/upright_capture_with_slew_limit_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the upright capture unit
// Concurrent assertion shorthands that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef UPRIGHT_CAPTURE_WITH_SLEW_LIMIT_UNIT_MACROS_SVH
`define UPRIGHT_CAPTURE_WITH_SLEW_LIMIT_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define UCSL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define UCSL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define UCSL_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UCSL_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/ucsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Upright capture package
// Word types, configuration layout and fixed constants of the unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ucsl_pkg;

	localparam int unsigned ADDR_W = 5;

	localparam logic [15:0] UPRIGHT   = 16'h8000;
	localparam logic [7:0]  COUNT_MAX = 8'd255;

	typedef enum logic [2:0] {
		REG_ENTER_ANGLE   = 3'd0,
		REG_ENTER_RATE    = 3'd1,
		REG_ENTER_PREDICT = 3'd2,
		REG_LEAD_TIME     = 3'd3,
		REG_EXIT_ANGLE    = 3'd4,
		REG_EXIT_RATE     = 3'd5,
		REG_BALANCE_SLEW  = 3'd6,
		REG_SWINGUP_SLEW  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [15:0]        pole_angle;
		logic signed [23:0] pole_rate;
		logic signed [15:0] cmd_request;
	} sample_t;

	typedef struct packed {
		logic               locked;
		logic signed [15:0] drive_command;
	} result_t;

	typedef struct packed {
		logic [15:0] enter_angle_limit;
		logic [22:0] enter_rate_limit;
		logic [15:0] enter_predict_limit;
		logic [15:0] lead_time;
		logic [15:0] exit_angle_limit;
		logic [22:0] exit_rate_limit;
		logic [14:0] balance_slew;
		logic [14:0] swingup_slew;
	} cfg_t;

	typedef struct packed {
		logic enter_ok;
		logic exit_bad;
	} flags_t;

	typedef struct packed {
		logic               lock;
		logic [7:0]         hold;
		logic [7:0]         lost;
		logic signed [15:0] cmd;
	} track_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ucsl_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel
// Valid/ready channel that carries one word of a given payload type.
// ----------------------------------------------------------------------------
`default_nettype none

interface ucsl_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/ucsl_predict.sv =====
// ----------------------------------------------------------------------------
// Capture window check
// Forms the upright error, rate magnitude and predicted error of one sample
// and compares them against the enter and exit limits.
// ----------------------------------------------------------------------------
`default_nettype none

module ucsl_predict (
	input  wire ucsl_pkg::sample_t sample,
	input  wire ucsl_pkg::cfg_t    cfg,
	output ucsl_pkg::flags_t       flags
);

	logic signed [16:0] err;
	logic [16:0]        aerr;
	logic signed [24:0] rate;
	logic [23:0]        arate;
	logic [39:0]        prod;
	logic [39:0]        prod_rnd;
	logic [23:0]        lead_mag;
	logic signed [25:0] lead;
	logic signed [25:0] pred;
	logic [25:0]        apred;

	always_comb begin
		err      = 17'(signed'(sample.pole_angle ^ ucsl_pkg::UPRIGHT));
		aerr     = err[16] ? unsigned'(-err) : unsigned'(err);
		rate     = 25'(sample.pole_rate);
		arate    = rate[24] ? 24'(unsigned'(-rate)) : 24'(unsigned'(rate));
		prod     = 40'(arate) * 40'(cfg.lead_time);
		prod_rnd = prod + 40'd32768;
		lead_mag = prod_rnd[39:16];
		lead     = rate[24] ? -signed'(26'(lead_mag)) : signed'(26'(lead_mag));
		pred     = 26'(err) + lead;
		apred    = pred[25] ? unsigned'(-pred) : unsigned'(pred);

		flags.enter_ok = (aerr < 17'(cfg.enter_angle_limit))
			&& (arate < 24'(cfg.enter_rate_limit))
			&& (apred < 26'(cfg.enter_predict_limit));
		flags.exit_bad = (aerr > 17'(cfg.exit_angle_limit))
			|| (arate > 24'(cfg.exit_rate_limit));
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ucsl_track.sv =====
// ----------------------------------------------------------------------------
// Lock tracker and slew limiter
// Next state of the capture lock, its hysteresis counters and the held
// drive command for one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module ucsl_track #(
	parameter int unsigned ENTER_SAMPLES = 5,
	parameter int unsigned EXIT_SAMPLES  = 10
) (
	input  wire ucsl_pkg::track_t  cur,
	input  wire ucsl_pkg::flags_t  flags,
	input  wire logic signed [15:0] cmd_request,
	input  wire logic [14:0]        balance_slew,
	input  wire logic [14:0]        swingup_slew,
	output ucsl_pkg::track_t        nxt
);

	logic signed [17:0] lim;
	logic signed [17:0] delta;
	logic signed [17:0] step;
	logic signed [17:0] sum;

	always_comb begin
		nxt = cur;
		if (!cur.lock) begin
			if (flags.enter_ok) begin
				if (cur.hold != ucsl_pkg::COUNT_MAX) begin
					nxt.hold = cur.hold + 8'd1;
				end
			end else begin
				nxt.hold = '0;
			end
			if (nxt.hold >= 8'(ENTER_SAMPLES)) begin
				nxt.lock = 1'b1;
				nxt.lost = '0;
			end
		end else begin
			if (flags.exit_bad) begin
				if (cur.lost != ucsl_pkg::COUNT_MAX) begin
					nxt.lost = cur.lost + 8'd1;
				end
			end else begin
				nxt.lost = '0;
			end
			if (nxt.lost >= 8'(EXIT_SAMPLES)) begin
				nxt.lock = 1'b0;
				nxt.hold = '0;
			end
		end

		lim   = signed'(18'(nxt.lock ? balance_slew : swingup_slew));
		delta = 18'(cmd_request) - 18'(cur.cmd);
		if (delta > lim) begin
			step = lim;
		end else if (delta < -lim) begin
			step = -lim;
		end else begin
			step = delta;
		end
		sum     = 18'(cur.cmd) + step;
		nxt.cmd = sum[15:0];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/upright_capture_with_slew_limit_unit.sv =====
// Flow: a result word is registered from the sample word in the input register
// once the output is free. Throughput: one sample word per cycle while results
// are taken; the window check, lock and command update are combinational.
// A result word that waits holds the input register and stalls new samples.
// Reset: arst_n clears the lock, both counters, the held command and all valid
// flags, and loads the configuration registers with their default limits.
// ----------------------------------------------------------------------------
// Upright capture with slew limit
// Hysteresis lock around the upright position followed by a slew-limited
// drive command, with an APB configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

`include "upright_capture_with_slew_limit_unit_macros.svh"

module upright_capture_with_slew_limit_unit #(
	parameter int unsigned ENTER_SAMPLES = 5,
	parameter int unsigned EXIT_SAMPLES  = 10
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	ucsl_stream_if.sink                       sample,
	ucsl_stream_if.source                     result,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [ucsl_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                  pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	ucsl_pkg::cfg_t     cfg_q;
	ucsl_pkg::reg_idx_t reg_idx;
	logic               cfg_wr;

	ucsl_pkg::sample_t  sample_s1;
	logic               valid_s1;
	ucsl_pkg::flags_t   flags_pre;
	ucsl_pkg::track_t   state_q;
	ucsl_pkg::track_t   state_nxt;
	logic               out_valid_q;

	logic out_free;
	logic ready_s1;
	logic fire;

	assign pready  = 1'b1;
	assign reg_idx = ucsl_pkg::reg_idx_t'(paddr[ucsl_pkg::ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			ucsl_pkg::REG_ENTER_ANGLE:   prdata = 32'(cfg_q.enter_angle_limit);
			ucsl_pkg::REG_ENTER_RATE:    prdata = 32'(cfg_q.enter_rate_limit);
			ucsl_pkg::REG_ENTER_PREDICT: prdata = 32'(cfg_q.enter_predict_limit);
			ucsl_pkg::REG_LEAD_TIME:     prdata = 32'(cfg_q.lead_time);
			ucsl_pkg::REG_EXIT_ANGLE:    prdata = 32'(cfg_q.exit_angle_limit);
			ucsl_pkg::REG_EXIT_RATE:     prdata = 32'(cfg_q.exit_rate_limit);
			ucsl_pkg::REG_BALANCE_SLEW:  prdata = 32'(cfg_q.balance_slew);
			ucsl_pkg::REG_SWINGUP_SLEW:  prdata = 32'(cfg_q.swingup_slew);
			default:                     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enter_angle_limit   <= 16'd1456;
			cfg_q.enter_rate_limit    <= 23'd65536;
			cfg_q.enter_predict_limit <= 16'd1820;
			cfg_q.lead_time           <= 16'd3277;
			cfg_q.exit_angle_limit    <= 16'd3641;
			cfg_q.exit_rate_limit     <= 23'd262144;
			cfg_q.balance_slew        <= 15'd2000;
			cfg_q.swingup_slew        <= 15'd800;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				ucsl_pkg::REG_ENTER_ANGLE:   cfg_q.enter_angle_limit   <= pwdata[15:0];
				ucsl_pkg::REG_ENTER_RATE:    cfg_q.enter_rate_limit    <= pwdata[22:0];
				ucsl_pkg::REG_ENTER_PREDICT: cfg_q.enter_predict_limit <= pwdata[15:0];
				ucsl_pkg::REG_LEAD_TIME:     cfg_q.lead_time           <= pwdata[15:0];
				ucsl_pkg::REG_EXIT_ANGLE:    cfg_q.exit_angle_limit    <= pwdata[15:0];
				ucsl_pkg::REG_EXIT_RATE:     cfg_q.exit_rate_limit     <= pwdata[22:0];
				ucsl_pkg::REG_BALANCE_SLEW:  cfg_q.balance_slew        <= pwdata[14:0];
				ucsl_pkg::REG_SWINGUP_SLEW:  cfg_q.swingup_slew        <= pwdata[14:0];
				default: begin
				end
			endcase
		end
	end

	// The input register takes a new word when it is empty or its word moves on.
	assign out_free     = !out_valid_q || result.ready;
	assign fire         = valid_s1 && out_free;
	assign ready_s1     = !valid_s1 || out_free;
	assign sample.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= sample.valid;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
				state_q     <= state_nxt;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			sample_s1 <= sample.payload;
		end
	end

	ucsl_predict u_predict (
		.sample (sample_s1),
		.cfg    (cfg_q),
		.flags  (flags_pre)
	);

	ucsl_track #(
		.ENTER_SAMPLES (ENTER_SAMPLES),
		.EXIT_SAMPLES  (EXIT_SAMPLES)
	) u_track (
		.cur          (state_q),
		.flags        (flags_pre),
		.cmd_request  (sample_s1.cmd_request),
		.balance_slew (cfg_q.balance_slew),
		.swingup_slew (cfg_q.swingup_slew),
		.nxt          (state_nxt)
	);

	assign result.valid                 = out_valid_q;
	assign result.payload.locked        = state_q.lock;
	assign result.payload.drive_command = state_q.cmd;

	`UCSL_ASSERT_IMP(a_hold_below_enter, clk, arst_n, !state_q.lock,
		state_q.hold < 8'(ENTER_SAMPLES))
	`UCSL_ASSERT_IMP(a_lost_below_exit, clk, arst_n, state_q.lock,
		state_q.lost < 8'(EXIT_SAMPLES))
	`UCSL_ASSERT_NXT(a_state_moves_on_fire, clk, arst_n, !fire,
		$stable(state_q))

endmodule

`default_nettype wire
